[src/fractal_value_noise_height_defines.svh]
// assertion macros for the height block
`ifndef FRACTAL_VALUE_NOISE_HEIGHT_DEFINES_SVH
`define FRACTAL_VALUE_NOISE_HEIGHT_DEFINES_SVH

`ifndef SYNTHESIS
`define FVNH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fvnh assertion failed");
`define FVNH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fvnh assertion failed");
`else
`define FVNH_ASSERT(lbl, prop)
`define FVNH_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[src/fvnh_pkg.sv]
package fvnh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NOISE_W   = 32;
  localparam int NUM_STAGES = 15;
  localparam int OCT_FIRST = 3;
  localparam int OCT_STAGES = 9;
  localparam int HASH_STAGES = 5;

  localparam logic [31:0] HASH_MUL_X  = 32'd49632;
  localparam logic [31:0] HASH_MUL_Z  = 32'd325176;
  localparam logic [31:0] HASH_ADD    = 32'd12345;
  localparam logic [31:0] HASH_MUL_SQ = 32'd15731;
  localparam logic [31:0] HASH_ADD_SQ = 32'd789221;
  localparam logic [31:0] HASH_ADD_T  = 32'd1376312589;
  localparam logic [31:0] HASH_MASK   = 32'h7fffffff;
  localparam logic signed [32:0] CORNER_ONE = 33'sd1073741824;

  localparam logic signed [50:0] WEIGHT_TENTH = 51'sd6554;
  localparam logic signed [29:0] OUT_MAX = 30'sd67108863;
  localparam logic signed [29:0] OUT_MIN = -30'sd67108864;

  localparam logic [1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [1:0] REG_FREQUENCY = 2'd1;

  localparam logic [15:0] AMPLITUDE_RESET = 16'd256;
  localparam logic [15:0] FREQUENCY_RESET = 16'd6554;

endpackage

[src/fvnh_hash.sv]
module fvnh_hash (
  input  logic                                   clk,
  input  logic [fvnh_pkg::HASH_STAGES-1:0]       adv,
  input  logic [31:0]                            cx,
  input  logic [31:0]                            cz,
  output logic signed [fvnh_pkg::NOISE_W-1:0]    corner
);

  logic [31:0] s0;
  logic [31:0] s1a, sq;
  logic [31:0] s1b, m;
  logic [31:0] t;
  logic [31:0] s1_comb;
  logic [31:0] t_masked;

  assign s1_comb  = (s0 << 13) ^ s0;
  assign t_masked = (t + fvnh_pkg::HASH_ADD_T) & fvnh_pkg::HASH_MASK;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0 <= cx * fvnh_pkg::HASH_MUL_X + cz * fvnh_pkg::HASH_MUL_Z + fvnh_pkg::HASH_ADD;
    end
    if (adv[1]) begin
      s1a <= s1_comb;
      sq  <= s1_comb * s1_comb;
    end
    if (adv[2]) begin
      s1b <= s1a;
      m   <= sq * fvnh_pkg::HASH_MUL_SQ + fvnh_pkg::HASH_ADD_SQ;
    end
    if (adv[3]) begin
      t <= s1b * m;
    end
    if (adv[4]) begin
      corner <= 32'(fvnh_pkg::CORNER_ONE - $signed({1'b0, t_masked}));
    end
  end

endmodule

[src/fvnh_octave.sv]
module fvnh_octave #(
  parameter int PXW = 29
) (
  input  logic                                   clk,
  input  logic [fvnh_pkg::OCT_STAGES-1:0]        adv,
  input  logic [PXW-1:0]                         px,
  input  logic [PXW-1:0]                         pz,
  output logic signed [fvnh_pkg::NOISE_W-1:0]    noise
);

  localparam int FB = fvnh_pkg::FRAC_BITS;
  localparam int HS = fvnh_pkg::HASH_STAGES;

  logic [31:0] ix, iz, ix1, iz1;
  logic signed [31:0] c00, c01, c10, c11;

  logic [FB-1:0] fx, fz;
  logic [2*FB-1:0] ffx, ffz;
  logic [FB-1:0] ux_d [3];
  logic [FB-1:0] uz_d [3];
  logic [FB-1:0] ux5, ux6, ux7, uz5;

  logic signed [50:0] plo, phi, pn;
  logic signed [31:0] alo, ahi, lo, hi, an;

  assign ix  = 32'(px[PXW-1:FB]);
  assign iz  = 32'(pz[PXW-1:FB]);
  assign ix1 = ix + 32'd1;
  assign iz1 = iz + 32'd1;

  fvnh_hash u_h00 (.clk(clk), .adv(adv[HS-1:0]), .cx(ix),  .cz(iz),  .corner(c00));
  fvnh_hash u_h01 (.clk(clk), .adv(adv[HS-1:0]), .cx(ix),  .cz(iz1), .corner(c01));
  fvnh_hash u_h10 (.clk(clk), .adv(adv[HS-1:0]), .cx(ix1), .cz(iz),  .corner(c10));
  fvnh_hash u_h11 (.clk(clk), .adv(adv[HS-1:0]), .cx(ix1), .cz(iz1), .corner(c11));

  function automatic logic [FB-1:0] smooth(input logic [FB-1:0] f, input logic [2*FB-1:0] ff);
    logic [17:0] k;
    logic [49:0] p;
    k = 18'd196608 - {1'b0, f, 1'b0};
    p = 50'(ff) * 50'(k);
    return p[2*FB+FB-1:2*FB];
  endfunction

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      fx  <= px[FB-1:0];
      fz  <= pz[FB-1:0];
      ffx <= px[FB-1:0] * px[FB-1:0];
      ffz <= pz[FB-1:0] * pz[FB-1:0];
    end
    if (adv[1]) begin
      ux_d[0] <= smooth(fx, ffx);
      uz_d[0] <= smooth(fz, ffz);
    end
    if (adv[2]) begin
      ux_d[1] <= ux_d[0];
      uz_d[1] <= uz_d[0];
    end
    if (adv[3]) begin
      ux_d[2] <= ux_d[1];
      uz_d[2] <= uz_d[1];
    end
    if (adv[4]) begin
      ux5 <= ux_d[2];
      uz5 <= uz_d[2];
    end
    // blend along z
    if (adv[5]) begin
      ux6 <= ux5;
      alo <= c00;
      ahi <= c10;
      plo <= 51'($signed({c01[31], c01}) - $signed({c00[31], c00})) *
             51'($signed({1'b0, uz5}));
      phi <= 51'($signed({c11[31], c11}) - $signed({c10[31], c10})) *
             51'($signed({1'b0, uz5}));
    end
    if (adv[6]) begin
      ux7 <= ux6;
      lo  <= alo + 32'(plo >>> FB);
      hi  <= ahi + 32'(phi >>> FB);
    end
    // blend along x
    if (adv[7]) begin
      an <= lo;
      pn <= 51'($signed({hi[31], hi}) - $signed({lo[31], lo})) *
            51'($signed({1'b0, ux7}));
    end
    if (adv[8]) begin
      noise <= an + 32'(pn >>> FB);
    end
  end

endmodule

[src/fractal_value_noise_height.sv]
// channel  | dir | payload
// s_axis   | in  | tdata: grid_x [9:0], grid_z [19:10]
// m_axis   | out | tdata: height_value [26:0]
// cfg      | in  | cfg_index, cfg_data (amplitude_gain, base_frequency)
//
// one grid point per cycle unless stalled; 15 register stages to result
// four hash pipelines per octave, three octaves, all in lock step
// each stage holds while it is full and the one after it is stalled
// synchronous reset empties the pipeline and restores the registers
`include "fractal_value_noise_height_defines.svh"

module fractal_value_noise_height #(
  parameter int COORD_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // grid_x, grid_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // height_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NS  = fvnh_pkg::NUM_STAGES;
  localparam int CW  = COORD_BITS;
  localparam int BW  = CW + 16;
  localparam int PXW = CW + 19;
  localparam int OF  = fvnh_pkg::OCT_FIRST;
  localparam int OL  = OF + fvnh_pkg::OCT_STAGES - 1;

  logic [15:0] amplitude_gain;
  logic [15:0] base_frequency;

  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  logic [CW-1:0] gx, gz;
  logic [BW-1:0] bx, bz;
  logic [PXW-1:0] bxe, bze;
  logic [PXW-1:0] p1x, p1z, p2x, p2z, p3x, p3z;
  logic signed [31:0] n1, n2, n3;
  logic signed [50:0] sum;
  logic signed [67:0] prod;
  logic signed [29:0] h;
  logic [26:0] height_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude_gain <= fvnh_pkg::AMPLITUDE_RESET;
      base_frequency <= fvnh_pkg::FREQUENCY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == fvnh_pkg::REG_AMPLITUDE) begin
        amplitude_gain <= cfg_data;
      end else if (cfg_index == fvnh_pkg::REG_FREQUENCY) begin
        base_frequency <= cfg_data;
      end
    end
  end

  always_comb begin
    adv[NS-1] = !vld[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign bxe = PXW'(bx);
  assign bze = PXW'(bz);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      gx <= CW'(s_axis_tdata[9:0]);
      gz <= CW'(s_axis_tdata[19:10]);
    end
    if (adv[1]) begin
      bx <= BW'(gx) * BW'(base_frequency);
      bz <= BW'(gz) * BW'(base_frequency);
    end
    if (adv[2]) begin
      p1x <= bxe;
      p1z <= bze;
      p2x <= ((bxe << 2) + bxe) >> 1;
      p2z <= ((bze << 2) + bze) >> 1;
      p3x <= (bxe << 2) + (bxe << 1);
      p3z <= (bze << 2) + (bze << 1);
    end
  end

  fvnh_octave #(.PXW(PXW)) u_oct1 (
    .clk(clk), .adv(adv[OL:OF]), .px(p1x), .pz(p1z), .noise(n1)
  );
  fvnh_octave #(.PXW(PXW)) u_oct2 (
    .clk(clk), .adv(adv[OL:OF]), .px(p2x), .pz(p2z), .noise(n2)
  );
  fvnh_octave #(.PXW(PXW)) u_oct3 (
    .clk(clk), .adv(adv[OL:OF]), .px(p3x), .pz(p3z), .noise(n3)
  );

  always_ff @(posedge clk) begin
    if (adv[OL+1]) begin
      sum <= (51'(n1) <<< 16) + (51'(n2) <<< 14) + 51'(n3) * fvnh_pkg::WEIGHT_TENTH;
    end
    if (adv[OL+2]) begin
      prod <= 68'(sum) * 68'($signed({1'b0, amplitude_gain}));
    end
    if (adv[OL+3]) begin
      height_value <= 27'(h);
    end
  end

  always_comb begin
    h = 30'(prod >>> 38);
    if (h > fvnh_pkg::OUT_MAX) begin
      h = fvnh_pkg::OUT_MAX;
    end else if (h < fvnh_pkg::OUT_MIN) begin
      h = fvnh_pkg::OUT_MIN;
    end
  end

  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata  = {5'd0, height_value};

  `FVNH_ASSERT(a_ready_when_empty_out, !m_axis_tvalid |-> s_axis_tready)
  `FVNH_ASSERT(a_request_enters, s_axis_tvalid && s_axis_tready |=> vld[0])
  `FVNH_ASSERT(a_empty_stays_quiet, (vld == '0) |=> !m_axis_tvalid)
  `FVNH_ASSERT_ALWAYS(a_reset_empties, rst |=> (vld == '0))

endmodule

[tb/fractal_value_noise_height_test.sv]
`timescale 1ns / 1ps

module fractal_value_noise_height_test;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    logic [15:0] amp;
    logic [15:0] freq;
    logic [9:0]  x;
    logic [9:0]  z;
    bit          known;
    logic [26:0] level;
  } point_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // grid_x, grid_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // height_value
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  logic [15:0] gain_q;
  logic [15:0] freq_q;
  logic [26:0] height_fifo[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  bit          failed;
  int          quiet_cycles;

  fractal_value_noise_height DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint lattice_value(logic [31:0] cx, logic [31:0] cz);
    logic [31:0] s;
    logic [31:0] t;
    s = cx * fvnh_pkg::HASH_MUL_X + cz * fvnh_pkg::HASH_MUL_Z + fvnh_pkg::HASH_ADD;
    s = (s << 13) ^ s;
    t = s * (s * s * fvnh_pkg::HASH_MUL_SQ + fvnh_pkg::HASH_ADD_SQ);
    t = (t + fvnh_pkg::HASH_ADD_T) & fvnh_pkg::HASH_MASK;
    return 64'sd1073741824 - longint'({32'b0, t});
  endfunction

  function automatic longint fade(logic [15:0] f);
    longint fl;
    longint p;
    fl = longint'({48'b0, f});
    p = fl * fl * (64'sd196608 - 2 * fl);
    return p >>> 32;
  endfunction

  function automatic longint lerp(longint a, longint b, longint u);
    return a + (((b - a) * u) >>> fvnh_pkg::FRAC_BITS);
  endfunction

  function automatic longint octave(longint px, longint pz);
    logic [31:0] ix;
    logic [31:0] iz;
    longint ux;
    longint uz;
    longint lo;
    longint hi;
    ix = px[47:16];
    iz = pz[47:16];
    ux = fade(px[15:0]);
    uz = fade(pz[15:0]);
    lo = lerp(lattice_value(ix, iz), lattice_value(ix, iz + 1), uz);
    hi = lerp(lattice_value(ix + 1, iz), lattice_value(ix + 1, iz + 1), uz);
    return lerp(lo, hi, ux);
  endfunction

  function automatic logic [26:0] terrain_height(logic [9:0] gx, logic [9:0] gz);
    longint bx;
    longint bz;
    longint total;
    longint h;
    bx = longint'({54'b0, gx}) * longint'({48'b0, freq_q});
    bz = longint'({54'b0, gz}) * longint'({48'b0, freq_q});
    total = octave(bx, bz) * 65536
          + octave((bx * 5) >>> 1, (bz * 5) >>> 1) * 16384
          + octave(bx * 6, bz * 6) * 6554;
    h = (total * longint'({48'b0, gain_q})) >>> 38;
    if (h > 64'sd67108863) h = 64'sd67108863;
    if (h < -64'sd67108864) h = -64'sd67108864;
    return h[26:0];
  endfunction

  // prediction on each accepted request
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      height_fifo = {height_fifo,
                     terrain_height(s_axis_tdata[9:0], s_axis_tdata[19:10])};
    end
  end

  // result check
  always @(posedge clk) begin
    logic [26:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (height_fifo.size() == 0) begin
        $display("%0t: unexpected height, got %h", $time, m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = height_fifo.pop_front();
        if (m_axis_tdata !== {5'b0, want}) begin
          $display("%0t: height mismatch, expected %h, got %h", $time, {5'b0, want},
                   m_axis_tdata);
          failed = 1'b1;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_req = 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fractal_value_noise_height_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == fvnh_pkg::REG_AMPLITUDE) gain_q = value;
    else if (idx == fvnh_pkg::REG_FREQUENCY) freq_q = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(logic [9:0] gx, logic [9:0] gz);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, gz, gx};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (height_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] amp, logic [15:0] freq);
    wait_idle();
    write_reg(fvnh_pkg::REG_AMPLITUDE, amp);
    write_reg(fvnh_pkg::REG_FREQUENCY, freq);
  endtask

  function automatic logic [15:0] pick_reg();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  point_row_t directed[] = '{
    '{16'd256, 16'd6554, 10'd0, 10'd0, 1'b0, 27'd0},
    '{16'd256, 16'd6554, 10'd1023, 10'd1023, 1'b0, 27'd0},
    '{16'd256, 16'd6554, 10'd1023, 10'd0, 1'b0, 27'd0},
    '{16'd256, 16'd6554, 10'd0, 10'd1023, 1'b0, 27'd0},
    '{16'd256, 16'd6554, 10'h2aa, 10'h155, 1'b0, 27'd0},
    '{16'd256, 16'd6554, 10'h155, 10'h2aa, 1'b0, 27'd0},
    '{16'd256, 16'd6554, 10'd1, 10'd1, 1'b0, 27'd0},
    '{16'd0, 16'd6554, 10'd1023, 10'd1023, 1'b1, 27'd0},
    '{16'd0, 16'd6554, 10'd0, 10'd0, 1'b1, 27'd0},
    '{16'd0, 16'hffff, 10'd1023, 10'd517, 1'b1, 27'd0},
    '{16'hffff, 16'hffff, 10'd0, 10'd0, 1'b0, 27'd0},
    '{16'hffff, 16'hffff, 10'd1023, 10'd1023, 1'b0, 27'd0},
    '{16'hffff, 16'hffff, 10'h2aa, 10'h155, 1'b0, 27'd0},
    '{16'hffff, 16'hffff, 10'd1, 10'd1022, 1'b0, 27'd0},
    '{16'hffff, 16'd0, 10'd1023, 10'd1023, 1'b0, 27'd0},
    '{16'hffff, 16'd0, 10'd0, 10'd0, 1'b0, 27'd0},
    '{16'hffff, 16'd1, 10'd1023, 10'd1023, 1'b0, 27'd0},
    '{16'd1, 16'd32768, 10'd3, 10'd5, 1'b0, 27'd0},
    '{16'h8000, 16'd65535, 10'd511, 10'd512, 1'b0, 27'd0}
  };

  initial begin
    int phase;
    failed = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gain_q = fvnh_pkg::AMPLITUDE_RESET;
    freq_q = fvnh_pkg::FREQUENCY_RESET;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= fvnh_pkg::REG_AMPLITUDE;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values must hold until the first write
    foreach (directed[i]) begin
      if (directed[i].amp != gain_q || directed[i].freq != freq_q) begin
        set_config(directed[i].amp, directed[i].freq);
      end
      if (directed[i].known) begin
        if (terrain_height(directed[i].x, directed[i].z) !== directed[i].level) begin
          $display("%0t: height mismatch, expected %h, got %h", $time,
                   directed[i].level, terrain_height(directed[i].x, directed[i].z));
          failed = 1'b1;
        end
      end
      send_point(directed[i].x, directed[i].z);
    end

    // writes to a spare index are dropped
    wait_idle();
    write_reg(REG_SPARE, 16'h0);
    write_reg(REG_SPARE - 2'd1, 16'hffff);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 13 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        set_config(pick_reg(), pick_reg());
        if (phase == 2 && blk == 1) hold_req = 1'b1;
        for (int n = 0; n < 62; n++) send_point(pick_coord(), pick_coord());
      end
    end

    wait_idle();
    if (!failed) begin
      $display("fractal_value_noise_height_test passed");
    end else begin
      $display("fractal_value_noise_height_test failed");
    end
    $finish;
  end

endmodule
